### src/flpt_pkg.sv
// Shared types and constants for the frame packet loss tracker.
// No dependencies; flpt_out_fifo, flpt_core and the top level import this package.
`timescale 1ns / 1ps

package flpt_pkg;

    // Field widths
    localparam int FRAME_W = 16;
    localparam int PNUM_W  = 16;
    localparam int EXP_W   = 11;
    localparam int WORDS_W = 14;
    localparam int OFFS_W  = 29;
    localparam int CNT_W   = 32;
    localparam int TOTAL_W = 11;
    localparam int CFG_W   = 14;

    // Operation codes
    localparam logic [1:0] OP_PACKET  = 2'd0;
    localparam logic [1:0] OP_TIMEOUT = 2'd1;
    localparam logic [1:0] OP_START   = 2'd2;

    // Configuration register indexes
    localparam logic REG_EXPECTED = 1'b0;
    localparam logic REG_WORDS    = 1'b1;

    typedef struct packed {
        logic [1:0]         op;
        logic               stream;
        logic [FRAME_W-1:0] frame_number;
        logic [PNUM_W-1:0]  packet_number;
    } item_t;

    typedef struct packed {
        logic               stream_out;
        logic               accepted;
        logic               was_duplicate;
        logic               skipped_ahead;
        logic               done_valid;
        logic [FRAME_W-1:0] done_frame;
        logic               done_complete;
        logic [OFFS_W-1:0]  write_offset;
        logic [CNT_W-1:0]   late_count;
        logic [CNT_W-1:0]   missing_count;
        logic [CNT_W-1:0]   duplicate_count;
        logic               last_result;
    } result_t;

endpackage

### src/flpt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module flpt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port; a read of the row being written returns old data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/flpt_out_fifo.sv
// Result queue: takes up to two results per cycle, hands out one beat per cycle while out_ready is high.
// Depends on flpt_pkg for result_t.
`timescale 1ns / 1ps

module flpt_out_fifo
    import flpt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push_one,
    input  logic    push_two,
    input  result_t push_a,
    input  result_t push_b,
    output logic    room_two,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;

    result_t          mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [PTR_W-1:0] wr_ptr_b;
    logic             pop;
    logic             push_any;

    assign pop      = out_valid && out_ready;
    assign push_any = push_one || push_two;
    assign wr_ptr_b = wr_ptr_reg + PTR_W'(1);
    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign room_two  = (count_reg <= CNT_W'(DEPTH - 2));

    // Count after this cycle's pushes and pop
    always_comb
    begin
        count_next = count_reg;
        if (push_two)
        begin
            count_next = count_next + CNT_W'(2);
        end
        else if (push_one)
        begin
            count_next = count_next + CNT_W'(1);
        end
        if (pop)
        begin
            count_next = count_next - CNT_W'(1);
        end
    end

    // Store pushed results
    always_ff @(posedge clk)
    begin
        if (push_any)
        begin
            mem[wr_ptr_reg] <= push_a;
        end
        if (push_two)
        begin
            mem[wr_ptr_b] <= push_b;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_two)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(2);
            end
            else if (push_one)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

### src/flpt_core.sv
// Per-stream tracking state and the decision logic for one registered beat.
// Depends on flpt_pkg; the bitmap rows come from a flpt_ram in the top level.
`timescale 1ns / 1ps

module flpt_core
    import flpt_pkg::*;
#(
    parameter int MAX_PACKETS = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  item_t               item,
    input  logic [(1 << ((($clog2(MAX_PACKETS) > 0) ? $clog2(MAX_PACKETS) : 1) > 12
                  ? ((($clog2(MAX_PACKETS) > 0) ? $clog2(MAX_PACKETS) : 1) - 7)
                  : (((($clog2(MAX_PACKETS) > 0) ? $clog2(MAX_PACKETS) : 1) > 6)
                  ? 5 : ((($clog2(MAX_PACKETS) > 0) ? $clog2(MAX_PACKETS) : 1) - 1))))-1:0]
                                row_raw,
    input  logic [EXP_W-1:0]    cfg_expected,
    input  logic [WORDS_W-1:0]  cfg_words,
    output logic                wr_en,
    output logic [((($clog2(MAX_PACKETS) > 0) ? $clog2(MAX_PACKETS) : 1)
                  - (((($clog2(MAX_PACKETS) > 0) ? $clog2(MAX_PACKETS) : 1) > 12)
                  ? ((($clog2(MAX_PACKETS) > 0) ? $clog2(MAX_PACKETS) : 1) - 7)
                  : (((($clog2(MAX_PACKETS) > 0) ? $clog2(MAX_PACKETS) : 1) > 6)
                  ? 5 : ((($clog2(MAX_PACKETS) > 0) ? $clog2(MAX_PACKETS) : 1) - 1))))
                  :0]           wr_addr,
    output logic [(1 << ((($clog2(MAX_PACKETS) > 0) ? $clog2(MAX_PACKETS) : 1) > 12
                  ? ((($clog2(MAX_PACKETS) > 0) ? $clog2(MAX_PACKETS) : 1) - 7)
                  : (((($clog2(MAX_PACKETS) > 0) ? $clog2(MAX_PACKETS) : 1) > 6)
                  ? 5 : ((($clog2(MAX_PACKETS) > 0) ? $clog2(MAX_PACKETS) : 1) - 1))))-1:0]
                                wr_data,
    output logic                push_one,
    output logic                push_two,
    output result_t             res_a,
    output result_t             res_b
);

    // Bitmap geometry: rows of ROW_W bits, ROWS rows per stream
    localparam int PN_W     = ($clog2(MAX_PACKETS) > 0) ? $clog2(MAX_PACKETS) : 1;
    localparam int ROW_LOG  = (PN_W > 12) ? (PN_W - 7) : ((PN_W > 6) ? 5 : (PN_W - 1));
    localparam int ROWS_LOG = PN_W - ROW_LOG;
    localparam int ROW_W    = 1 << ROW_LOG;
    localparam int ROWS     = 1 << ROWS_LOG;
    localparam int ADDR_W   = ROWS_LOG + 1;
    localparam int SUM_W    = TOTAL_W + 1;
    localparam int PROD_W   = WORDS_W + PNUM_W;

    logic               expect_new_reg  [2];
    logic               expect_new_next [2];
    logic [FRAME_W-1:0] cur_frame_reg   [2];
    logic [FRAME_W-1:0] cur_frame_next  [2];
    logic [TOTAL_W-1:0] total_reg       [2];
    logic [TOTAL_W-1:0] total_next      [2];
    logic [CNT_W-1:0]   late_reg        [2];
    logic [CNT_W-1:0]   late_next       [2];
    logic [CNT_W-1:0]   miss_reg        [2];
    logic [CNT_W-1:0]   miss_next       [2];
    logic [CNT_W-1:0]   dup_reg         [2];
    logic [CNT_W-1:0]   dup_next        [2];
    logic [2*ROWS-1:0]  row_valid_reg;
    logic [2*ROWS-1:0]  row_valid_next;

    logic [EXP_W-1:0]    exp_eff;
    logic [PNUM_W-1:0]   pn_shift;
    logic [PNUM_W-1:0]   bit_idx;
    logic [ADDR_W-1:0]   addr;
    logic [ROW_W-1:0]    bit_mask;
    logic [ROW_W-1:0]    row_eff;
    logic [ROW_W-1:0]    base_row;
    logic [PROD_W-1:0]   product;
    logic [OFFS_W-1:0]   offset;
    logic                s;
    logic                skip;
    logic                dup;
    logic                done;
    logic [SUM_W-1:0]    total_base;
    logic [SUM_W-1:0]    total_sum;
    logic [CNT_W-1:0]    late_upd;
    logic [CNT_W-1:0]    miss_upd;
    logic [CNT_W-1:0]    dup_upd;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + CNT_W'(1);
    endfunction

    // Clamp the expected count into 1..MAX_PACKETS
    always_comb
    begin
        if (cfg_expected == '0)
        begin
            exp_eff = EXP_W'(1);
        end
        else if (32'(cfg_expected) > 32'(MAX_PACKETS))
        begin
            exp_eff = EXP_W'(MAX_PACKETS);
        end
        else
        begin
            exp_eff = cfg_expected;
        end
    end

    // Locate the packet's bit in the bitmap
    assign s        = item.stream;
    assign pn_shift = item.packet_number >> ROW_LOG;
    assign bit_idx  = item.packet_number & PNUM_W'(ROW_W - 1);
    assign addr     = {s, pn_shift[ROWS_LOG-1:0]};
    assign bit_mask = ROW_W'(1) << bit_idx;
    assign row_eff  = row_valid_reg[addr] ? row_raw : '0;

    // Word offset of the payload
    assign product = PROD_W'(cfg_words) * PROD_W'(item.packet_number);
    assign offset  = product[OFFS_W-1:0];

    assign wr_addr = addr;

    // Decide the beat: next state, bitmap write and results
    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            expect_new_next[k] = expect_new_reg[k];
            cur_frame_next[k]  = cur_frame_reg[k];
            total_next[k]      = total_reg[k];
            late_next[k]       = late_reg[k];
            miss_next[k]       = miss_reg[k];
            dup_next[k]        = dup_reg[k];
        end
        row_valid_next = row_valid_reg;
        wr_en      = 1'b0;
        wr_data    = '0;
        push_one   = 1'b0;
        push_two   = 1'b0;
        res_a      = '0;
        res_b      = '0;
        skip       = 1'b0;
        dup        = 1'b0;
        done       = 1'b0;
        base_row   = '0;
        total_base = '0;
        total_sum  = '0;
        late_upd   = late_reg[s];
        miss_upd   = miss_reg[s];
        dup_upd    = dup_reg[s];

        unique case (item.op)
            OP_TIMEOUT:
            begin
                // Drop the image stream's frame, keep its counters
                expect_new_next[0] = 1'b1;
                cur_frame_next[0]  = '0;
                total_next[0]      = '0;
                for (int i = 0; i < 2*ROWS; i++)
                begin
                    if (i < ROWS)
                    begin
                        row_valid_next[i] = 1'b0;
                    end
                end
            end
            OP_START:
            begin
                // Restart both streams from scratch
                for (int k = 0; k < 2; k++)
                begin
                    expect_new_next[k] = 1'b1;
                    cur_frame_next[k]  = '0;
                    total_next[k]      = '0;
                    late_next[k]       = '0;
                    miss_next[k]       = '0;
                    dup_next[k]        = '0;
                end
                row_valid_next = '0;
            end
            OP_PACKET:
            begin
                res_a.stream_out      = s;
                res_a.last_result     = 1'b1;
                res_a.late_count      = late_reg[s];
                res_a.missing_count   = miss_reg[s];
                res_a.duplicate_count = dup_reg[s];
                push_one = 1'b1;
                if (32'(item.packet_number) >= 32'(exp_eff))
                begin
                    // Packet number outside the frame: drop without counting
                end
                else if (!expect_new_reg[s] && (item.frame_number < cur_frame_reg[s]))
                begin
                    // Late packet: drop and count
                    late_upd           = sat_inc(late_reg[s]);
                    late_next[s]       = late_upd;
                    res_a.late_count   = late_upd;
                end
                else
                begin
                    skip = !expect_new_reg[s] && (item.frame_number > cur_frame_reg[s]);
                    if (skip)
                    begin
                        miss_upd     = sat_inc(miss_reg[s]);
                        miss_next[s] = miss_upd;
                        base_row     = '0;
                        total_base   = '0;
                    end
                    else
                    begin
                        base_row   = row_eff;
                        total_base = SUM_W'(total_reg[s]);
                    end
                    dup = |(base_row & bit_mask);
                    if (dup)
                    begin
                        dup_upd     = sat_inc(dup_reg[s]);
                        dup_next[s] = dup_upd;
                        total_sum   = total_base;
                    end
                    else
                    begin
                        total_sum = total_base + SUM_W'(1);
                    end
                    done = (total_sum >= SUM_W'(exp_eff));

                    // Mark the packet's row, then close the frame if it is full
                    wr_en   = 1'b1;
                    wr_data = base_row | bit_mask;
                    if (skip)
                    begin
                        for (int i = 0; i < 2*ROWS; i++)
                        begin
                            if ((i >= ROWS) == s)
                            begin
                                row_valid_next[i] = 1'b0;
                            end
                        end
                    end
                    row_valid_next[addr] = 1'b1;
                    cur_frame_next[s]    = item.frame_number;
                    if (done)
                    begin
                        for (int i = 0; i < 2*ROWS; i++)
                        begin
                            if ((i >= ROWS) == s)
                            begin
                                row_valid_next[i] = 1'b0;
                            end
                        end
                        total_next[s]      = '0;
                        expect_new_next[s] = 1'b1;
                    end
                    else
                    begin
                        total_next[s]      = total_sum[TOTAL_W-1:0];
                        expect_new_next[s] = 1'b0;
                    end

                    // Packet result
                    res_b.stream_out      = s;
                    res_b.accepted        = 1'b1;
                    res_b.was_duplicate   = dup;
                    res_b.skipped_ahead   = skip;
                    res_b.done_valid      = done;
                    res_b.done_frame      = done ? item.frame_number : '0;
                    res_b.done_complete   = done;
                    res_b.write_offset    = offset;
                    res_b.late_count      = late_reg[s];
                    res_b.missing_count   = miss_upd;
                    res_b.duplicate_count = dup_upd;
                    res_b.last_result     = 1'b1;

                    if (skip)
                    begin
                        // Closed-frame report goes first
                        res_a.skipped_ahead = 1'b1;
                        res_a.done_valid    = 1'b1;
                        res_a.done_frame    = cur_frame_reg[s];
                        res_a.missing_count = miss_upd;
                        res_a.last_result   = 1'b0;
                        push_one = 1'b0;
                        push_two = 1'b1;
                    end
                    else
                    begin
                        res_a = res_b;
                    end
                end
            end
            default:
            begin
                // Reserved code: no effect
            end
        endcase

        if (!fire)
        begin
            wr_en    = 1'b0;
            push_one = 1'b0;
            push_two = 1'b0;
        end
    end

    // Commit state on each processed beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 2; k++)
            begin
                expect_new_reg[k] <= 1'b1;
                cur_frame_reg[k]  <= '0;
                total_reg[k]      <= '0;
                late_reg[k]       <= '0;
                miss_reg[k]       <= '0;
                dup_reg[k]        <= '0;
            end
            row_valid_reg <= '0;
        end
        else if (fire)
        begin
            for (int k = 0; k < 2; k++)
            begin
                expect_new_reg[k] <= expect_new_next[k];
                cur_frame_reg[k]  <= cur_frame_next[k];
                total_reg[k]      <= total_next[k];
                late_reg[k]       <= late_next[k];
                miss_reg[k]       <= miss_next[k];
                dup_reg[k]        <= dup_next[k];
            end
            row_valid_reg <= row_valid_next;
        end
    end

endmodule

### src/frame_packet_loss_tracker_unit.sv
// Top level of the frame packet loss tracker: input register, bitmap RAM, config.
// Depends on flpt_pkg, flpt_ram, flpt_core and flpt_out_fifo.
`timescale 1ns / 1ps

// A taken beat waits in the item register and is decided once the result queue has
// room for two results. Throughput: one input beat per cycle while the queue has that room;
// the result queue drains one beat per cycle while m_tready is high, so a packet that
// opens a newer frame (two results) costs an extra output beat.
// The bitmap row is read from RAM when the beat is taken; a row written by the
// beat just ahead is forwarded. Reset clears all tracking state and row-valid
// bits at once (no clearing pass); both config registers reset to 1.
module frame_packet_loss_tracker_unit
    import flpt_pkg::*;
#(
    parameter int MAX_PACKETS = 1024
) (
    input  logic         clk,
    input  logic         rst_n,
    // slave side
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // frame_number[15:0], packet_number[31:16]
    input  logic [2:0]   s_tuser,   // operation[1:0], stream[2]
    // master side
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [151:0] m_tdata,   // accepted[0], was_duplicate[1], skipped_ahead[2],
                                    // done_valid[3], done_frame[19:4], done_complete[20],
                                    // write_offset[49:21], late_count[81:50],
                                    // missing_count[113:82], duplicate_count[145:114], zero pad
    output logic [0:0]   m_tuser,   // stream_out[0]
    output logic         m_tlast,   // last_result
    // configuration write port
    input  logic         cfg_we,
    input  logic [0:0]   cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int PN_W     = ($clog2(MAX_PACKETS) > 0) ? $clog2(MAX_PACKETS) : 1;
    localparam int ROW_LOG  = (PN_W > 12) ? (PN_W - 7) : ((PN_W > 6) ? 5 : (PN_W - 1));
    localparam int ROWS_LOG = PN_W - ROW_LOG;
    localparam int ROW_W    = 1 << ROW_LOG;
    localparam int ADDR_W   = ROWS_LOG + 1;
    localparam int DEPTH    = 1 << ADDR_W;

    logic [EXP_W-1:0]   expected_reg;
    logic [WORDS_W-1:0] words_reg;
    item_t              item_reg;
    logic               item_valid_reg;
    logic               fwd_valid_reg;
    logic [ROW_W-1:0]   fwd_data_reg;

    logic               accept;
    logic               fire;
    logic               room_two;
    logic [PNUM_W-1:0]  in_pn_shift;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ROW_W-1:0]   ram_rdata;
    logic [ROW_W-1:0]   row_raw;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ROW_W-1:0]   wr_data;
    logic               push_one;
    logic               push_two;
    result_t            res_a;
    result_t            res_b;
    result_t            head;

    // Handshake: the item register advances whenever its beat is processed
    assign fire     = item_valid_reg && room_two;
    assign s_tready = !item_valid_reg || fire;
    assign accept   = s_tvalid && s_tready;

    // Bitmap row address of the incoming beat
    assign in_pn_shift = s_tdata[31:16] >> ROW_LOG;
    assign rd_addr     = {s_tuser[2], in_pn_shift[ROWS_LOG-1:0]};
    assign row_raw     = fwd_valid_reg ? fwd_data_reg : ram_rdata;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reg <= EXP_W'(1);
            words_reg    <= WORDS_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_EXPECTED: expected_reg <= cfg_data[EXP_W-1:0];
                REG_WORDS:    words_reg    <= cfg_data[WORDS_W-1:0];
                default:      ;
            endcase
        end
    end

    // Hold the accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            fwd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                item_valid_reg <= 1'b1;
                fwd_valid_reg  <= wr_en && (wr_addr == rd_addr);
            end
            else if (fire)
            begin
                item_valid_reg <= 1'b0;
            end
        end
    end

    // Payload of the held beat and the forwarded row
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.op            <= s_tuser[1:0];
            item_reg.stream        <= s_tuser[2];
            item_reg.frame_number  <= s_tdata[15:0];
            item_reg.packet_number <= s_tdata[31:16];
            fwd_data_reg           <= wr_data;
        end
    end

    flpt_ram #(
        .WIDTH (ROW_W),
        .DEPTH (DEPTH)
    ) u_bitmap (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    flpt_core #(
        .MAX_PACKETS (MAX_PACKETS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .item         (item_reg),
        .row_raw      (row_raw),
        .cfg_expected (expected_reg),
        .cfg_words    (words_reg),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .push_one     (push_one),
        .push_two     (push_two),
        .res_a        (res_a),
        .res_b        (res_b)
    );

    flpt_out_fifo u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_one  (push_one),
        .push_two  (push_two),
        .push_a    (res_a),
        .push_b    (res_b),
        .room_two  (room_two),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (head)
    );

    // Pack the result beat
    assign m_tdata = {6'd0, head.duplicate_count, head.missing_count, head.late_count,
                      head.write_offset, head.done_complete, head.done_frame,
                      head.done_valid, head.skipped_ahead, head.was_duplicate,
                      head.accepted};
    assign m_tuser = head.stream_out;
    assign m_tlast = head.last_result;

endmodule
